/* rtl/segmented_trie_prefix_lookup_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the segmented trie prefix lookup unit
// Implication checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef SEGMENTED_TRIE_PREFIX_LOOKUP_UNIT_MACROS_SVH
`define SEGMENTED_TRIE_PREFIX_LOOKUP_UNIT_MACROS_SVH

// Same-cycle implication.
`define STPL_ASSERT_IMP(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication.
`define STPL_ASSERT_NXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* rtl/stpl_pkg.sv */
// ----------------------------------------------------------------------------
// stpl_pkg
// Shared types and codes of the segmented trie prefix lookup unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stpl_pkg;

	localparam int SEG_BITS = 16;
	localparam logic [5:0] MAX_LEN = 6'd32;
	localparam logic [5:0] DIRECT_LEN = 6'd16;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	localparam logic STATUS_DONE = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SEG,
		S_ROOT,
		S_DIR,
		S_TREAD,
		S_TSTEP,
		S_TALLOC,
		S_LCHK,
		S_LSTEP,
		S_FIN
	} state_t;

	typedef enum logic [1:0] {
		RES_INS_OK,
		RES_INS_FULL,
		RES_LOOKUP
	} res_t;

	typedef struct packed {
		logic clr_en;
		logic load;
		logic seg_rd;
		logic root_latch;
		logic dir_wr;
		logic alloc_root;
		logic node_rd;
		logic ins_follow;
		logic ins_link;
		logic ins_alloc;
		logic ins_sethop;
		logic lk_take;
		logic lk_adv;
		logic out_ld;
		res_t out_kind;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_lookup;
		logic short_pfx;
		logic dir_last;
		logic root_null;
		logic pool_full;
		logic steps_done;
		logic link_null;
		logic cur_bad;
		logic nxt_bad;
		logic lk_last;
		logic out_busy;
	} sts_t;

endpackage

/* rtl/stpl_ctrl.sv */
// ----------------------------------------------------------------------------
// stpl_ctrl
// Sequencer: clearing pass, direct sweep, trie insert and trie walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stpl_ctrl import stpl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t st,
	output cmd_t cmd
);

	state_t state_q, state_n;
	res_t kind_q, kind_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			kind_q <= RES_INS_OK;
		end else begin
			state_q <= state_n;
			kind_q <= kind_n;
		end
	end

	always_comb begin
		state_n = state_q;
		kind_n = kind_q;
		cmd = '0;
		cmd.out_kind = kind_q;
		in_ready = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (st.clr_last) state_n = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n = S_SEG;
				end
			end
			S_SEG: begin
				cmd.seg_rd = 1'b1;
				state_n = S_ROOT;
			end
			S_ROOT: begin
				cmd.root_latch = 1'b1;
				if (st.is_lookup) begin
					state_n = S_LCHK;
				end else if (st.short_pfx) begin
					state_n = S_DIR;
				end else if (st.root_null && st.pool_full) begin
					kind_n = RES_INS_FULL;
					state_n = S_FIN;
				end else begin
					cmd.alloc_root = st.root_null;
					state_n = S_TREAD;
				end
			end
			S_DIR: begin
				cmd.dir_wr = 1'b1;
				if (st.dir_last) begin
					kind_n = RES_INS_OK;
					state_n = S_FIN;
				end
			end
			S_TREAD: begin
				cmd.node_rd = 1'b1;
				state_n = S_TSTEP;
			end
			S_TSTEP: begin
				if (st.steps_done) begin
					cmd.ins_sethop = 1'b1;
					kind_n = RES_INS_OK;
					state_n = S_FIN;
				end else if (!st.link_null) begin
					cmd.ins_follow = 1'b1;
				end else if (st.pool_full) begin
					kind_n = RES_INS_FULL;
					state_n = S_FIN;
				end else begin
					cmd.ins_link = 1'b1;
					state_n = S_TALLOC;
				end
			end
			S_TALLOC: begin
				cmd.ins_alloc = 1'b1;
				state_n = S_TREAD;
			end
			S_LCHK: begin
				kind_n = RES_LOOKUP;
				if (st.cur_bad) begin
					state_n = S_FIN;
				end else begin
					cmd.node_rd = 1'b1;
					state_n = S_LSTEP;
				end
			end
			S_LSTEP: begin
				cmd.lk_take = 1'b1;
				if (st.lk_last || st.nxt_bad) state_n = S_FIN;
				else cmd.lk_adv = 1'b1;
			end
			S_FIN: begin
				if (!st.out_busy) begin
					cmd.out_ld = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_CLEAR;
		endcase
	end

endmodule

/* rtl/stpl_datapath.sv */
// ----------------------------------------------------------------------------
// stpl_datapath
// Direct table, segment roots, node pool, walk registers and output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stpl_datapath import stpl_pkg::*; #(
	parameter int SEGMENTS = 65536,
	parameter int NODES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        st,
	input  logic        action,
	input  logic [31:0] address,
	input  logic [5:0]  prefix_len,
	input  logic [7:0]  hop_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic [7:0]  hop_out,
	output logic        status
);

	localparam int SEG_W = $clog2(SEGMENTS);
	localparam int NODE_W = $clog2(NODES);
	localparam int NW = 2 * NODE_W + 9;
	localparam int VALID_B = 8;
	localparam int RIGHT_LO = 9;
	localparam int LEFT_LO = 9 + NODE_W;

	// Remainder by the segment count, one conditional subtract per quotient bit.
	function automatic logic [SEG_W-1:0] seg_mod(input logic [15:0] v);
		logic [23:0] r;
		r = {8'd0, v};
		for (int j = 7; j >= 0; j--) begin
			if (r >= (24'(SEGMENTS) << j)) r = r - (24'(SEGMENTS) << j);
		end
		return r[SEG_W-1:0];
	endfunction

	logic [8:0]        direct_mem [SEGMENTS];
	logic [NODE_W-1:0] root_mem   [SEGMENTS];
	logic [NW-1:0]     node_mem   [NODES];

	logic              action_q;
	logic [31:0]       addr_q;
	logic [5:0]        len_q;
	logic [7:0]        hop_q;
	logic [SEG_W-1:0]  seg_q, didx_q, clr_q;
	logic [16:0]       k_q;
	logic [8:0]        direct_q;
	logic [NODE_W-1:0] root_q, cur_q;
	logic [NW-1:0]     node_q;
	logic [NODE_W:0]   nf_q;
	logic [4:0]        step_q;
	logic              found_q;
	logic [7:0]        best_q;

	logic [16:0]       span_m1;
	logic [15:0]       start;
	logic              bit_sel;
	logic [NODE_W-1:0] link;
	logic [NODE_W-1:0] node_ra;
	logic              node_re;
	logic              node_we;
	logic [NODE_W-1:0] node_wa;
	logic [NW-1:0]     node_wd;
	logic [NW-1:0]     linked;

	assign span_m1 = (17'd1 << (5'd16 - len_q[4:0])) - 17'd1;
	assign start = addr_q[31:16] & ~span_m1[15:0];
	assign bit_sel = (step_q[4]) ? 1'b0 : addr_q[4'(4'd15 - step_q[3:0])];
	assign link = bit_sel ? node_q[RIGHT_LO +: NODE_W] : node_q[LEFT_LO +: NODE_W];

	always_comb begin
		linked = node_q;
		if (bit_sel) linked[RIGHT_LO +: NODE_W] = nf_q[NODE_W-1:0];
		else linked[LEFT_LO +: NODE_W] = nf_q[NODE_W-1:0];
	end

	assign node_re = cmd.node_rd | cmd.ins_follow | cmd.lk_adv;
	assign node_ra = cmd.node_rd ? cur_q : link;

	always_comb begin
		node_we = 1'b0;
		node_wa = cur_q;
		node_wd = '0;
		if (cmd.alloc_root || cmd.ins_alloc) begin
			node_we = 1'b1;
			node_wa = nf_q[NODE_W-1:0];
		end else if (cmd.ins_link) begin
			node_we = 1'b1;
			node_wd = linked;
		end else if (cmd.ins_sethop && !node_q[VALID_B]) begin
			node_we = 1'b1;
			node_wd = {node_q[NW-1:RIGHT_LO], 1'b1, hop_q};
		end
	end

	always_ff @(posedge clk) begin
		if (node_we) node_mem[node_wa] <= node_wd;
		if (node_re) node_q <= node_mem[node_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_en) begin
			direct_mem[clr_q] <= '0;
			root_mem[clr_q] <= '0;
		end else begin
			if (cmd.dir_wr) direct_mem[didx_q] <= {1'b1, hop_q};
			if (cmd.alloc_root) root_mem[seg_q] <= nf_q[NODE_W-1:0];
		end
		if (cmd.seg_rd) begin
			direct_q <= direct_mem[seg_mod(addr_q[31:16])];
			root_q <= root_mem[seg_mod(addr_q[31:16])];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			addr_q <= address;
			len_q <= (prefix_len > MAX_LEN) ? MAX_LEN : prefix_len;
			hop_q <= hop_in;
		end
		if (cmd.seg_rd) begin
			seg_q <= seg_mod(addr_q[31:16]);
			didx_q <= seg_mod(start);
			k_q <= '0;
		end
		if (cmd.dir_wr) begin
			k_q <= k_q + 17'd1;
			didx_q <= (didx_q == SEG_W'(SEGMENTS - 1)) ? '0 : didx_q + 1'b1;
		end
		if (cmd.alloc_root) cur_q <= nf_q[NODE_W-1:0];
		else if (cmd.root_latch) cur_q <= root_q;
		else if (cmd.ins_follow || cmd.lk_adv) cur_q <= link;
		else if (cmd.ins_link) cur_q <= nf_q[NODE_W-1:0];
		if (cmd.root_latch) step_q <= '0;
		else if (cmd.ins_follow || cmd.lk_adv || cmd.ins_alloc) step_q <= step_q + 5'd1;
		if (cmd.root_latch) found_q <= 1'b0;
		else if (cmd.lk_take && node_q[VALID_B]) begin
			found_q <= 1'b1;
			best_q <= node_q[7:0];
		end
		if (cmd.out_ld) begin
			case (cmd.out_kind)
				RES_LOOKUP: begin
					hit <= found_q | direct_q[8];
					hop_out <= found_q ? best_q : (direct_q[8] ? direct_q[7:0] : 8'd0);
					status <= STATUS_DONE;
				end
				RES_INS_FULL: begin
					hit <= 1'b0;
					hop_out <= 8'd0;
					status <= STATUS_FULL;
				end
				default: begin
					hit <= 1'b0;
					hop_out <= 8'd0;
					status <= STATUS_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			nf_q <= (NODE_W+1)'(1);
			out_valid <= 1'b0;
		end else begin
			if (cmd.clr_en) clr_q <= clr_q + 1'b1;
			if (cmd.alloc_root || cmd.ins_alloc) nf_q <= nf_q + 1'b1;
			if (cmd.out_ld) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	always_comb begin
		st.clr_last = (clr_q == SEG_W'(SEGMENTS - 1));
		st.is_lookup = (action_q == ACT_LOOKUP);
		st.short_pfx = (len_q <= DIRECT_LEN);
		st.dir_last = (k_q == span_m1);
		st.root_null = (root_q == '0);
		st.pool_full = (nf_q >= (NODE_W+1)'(NODES));
		st.steps_done = (step_q == 5'(len_q - DIRECT_LEN));
		st.link_null = (link == '0);
		st.cur_bad = (cur_q == '0) || ({1'b0, cur_q} >= (NODE_W+1)'(NODES));
		st.nxt_bad = (link == '0) || ({1'b0, link} >= (NODE_W+1)'(NODES));
		st.lk_last = (step_q == 5'd16);
		st.out_busy = out_valid && !out_ready;
	end

endmodule

/* rtl/segmented_trie_prefix_lookup_unit.sv */
// ----------------------------------------------------------------------------
// segmented_trie_prefix_lookup_unit
// IPv4 longest-prefix match over direct segment entries and per-segment tries.
// ----------------------------------------------------------------------------
//  channel | signals                                    | handshake
//  in      | action, address, prefix_len, hop_in        | in_valid / in_ready
//  out     | hit, hop_out, status                       | out_valid / out_ready
//
// After reset a clearing pass zeroes the direct and root tables; no word is taken
// meanwhile. A lookup reads one node per trie level visited (up to 17 node reads
// on the single node pool port). A short insert sweeps 2^(16-len) direct entries, one per
// cycle. A long insert follows each level that exists and, for each level it lacks, links,
// allocates and reads the new node. A result word waits in the output register while
// out_ready is low; the next word is accepted once the previous result has been loaded.
`timescale 1ns / 1ps
`include "segmented_trie_prefix_lookup_unit_macros.svh"

module segmented_trie_prefix_lookup_unit import stpl_pkg::*; #(
	parameter int SEGMENTS = 65536,
	parameter int NODES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [31:0] address,
	input  logic [5:0]  prefix_len,
	input  logic [7:0]  hop_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        hit,
	output logic [7:0]  hop_out,
	output logic        status
);

	cmd_t cmd;
	sts_t st;

	stpl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	stpl_datapath #(
		.SEGMENTS (SEGMENTS),
		.NODES    (NODES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.action     (action),
		.address    (address),
		.prefix_len (prefix_len),
		.hop_in     (hop_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.hit        (hit),
		.hop_out    (hop_out),
		.status     (status)
	);

	`STPL_ASSERT_NXT(a_one_word, in_valid && in_ready, !in_ready, "second word taken early")
	`STPL_ASSERT_IMP(a_no_overwrite, cmd.out_ld, !st.out_busy, "result overwritten")
	`STPL_ASSERT_IMP(a_one_write, 1'b1,
		$onehot0({cmd.alloc_root, cmd.ins_link, cmd.ins_alloc, cmd.ins_sethop}),
		"node port written twice")
	`STPL_ASSERT_IMP(a_full_no_alloc, st.pool_full, !(cmd.alloc_root || cmd.ins_alloc),
		"allocation past pool end")

endmodule
